/* design/m3vt_pkg.sv */
// ----------------------------------------------------------------------------
// m3vt_pkg
// Shared types and constants for the 3x3 matrix transform with
// renormalization.
// ----------------------------------------------------------------------------
package m3vt_pkg;

    localparam int ROW_W    = 54;
    localparam int IN_W     = 18;
    localparam int OUT_W    = 24;
    localparam int FRAC_W   = 15;
    localparam int SQ_W     = 2 * OUT_W;
    localparam int NORM_W   = SQ_W + 2;
    localparam int QUO_W    = 33;
    localparam int ROOT_W   = 17;
    localparam int UNIT_W   = 16;
    localparam int DIV_LAT  = QUO_W;
    localparam int SQRT_LAT = ROOT_W;
    localparam int SIDE_LAT = DIV_LAT + SQRT_LAT;

    localparam logic [OUT_W-1:0] OUT_MAX     = 24'd8388607;
    localparam logic [OUT_W-1:0] OUT_MIN_MAG = 24'd8388608;

    localparam logic [ROW_W-1:0] ROW0_RST = 54'd131072;
    localparam logic [ROW_W-1:0] ROW1_RST = 54'd34359738368;
    localparam logic [ROW_W-1:0] ROW2_RST = 54'd9007199254740992;

    typedef enum logic [1:0] {
        REG_ROW0  = 2'd0,
        REG_ROW1  = 2'd1,
        REG_ROW2  = 2'd2,
        REG_RENRM = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                  vld;
        logic                  ren;
        logic                  degen;
        logic [2:0][OUT_W-1:0] p;
    } t_side;

endpackage

/* design/matrix3_vector_transform_normalize.sv */
// ----------------------------------------------------------------------------
// matrix3_vector_transform_normalize
// Multiplies each Q2.15 vector by a configured 3x3 matrix and optionally
// scales the Q8.15 product to unit length.
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries x, y, z. Output channel
//   o_out_valid / i_out_ready carries x, y, z and the degenerate flag.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at
//   the clock edge; write them only while the pipeline is empty.
//   Data passes from input transfer to output valid through the multiply
//   and round, the squared length, the divider (one quotient bit per
//   stage), the square root (one root bit per stage) and the output
//   register. One item per cycle is sustained unless the output stalls.
//   The whole pipeline advances together; when a result waits with
//   i_out_ready low, every stage holds and o_in_ready is low.
//   Reset clears all valid bits and loads the matrix and enable defaults.
// ----------------------------------------------------------------------------
module matrix3_vector_transform_normalize #(
    parameter int COEF_WIDTH = 18
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_idx,
    input  logic [m3vt_pkg::ROW_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [m3vt_pkg::IN_W-1:0]   i_in_x,
    input  logic signed [m3vt_pkg::IN_W-1:0]   i_in_y,
    input  logic signed [m3vt_pkg::IN_W-1:0]   i_in_z,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [m3vt_pkg::OUT_W-1:0]  o_out_x,
    output logic signed [m3vt_pkg::OUT_W-1:0]  o_out_y,
    output logic signed [m3vt_pkg::OUT_W-1:0]  o_out_z,
    output logic                               o_out_degenerate
);

    localparam int OW = m3vt_pkg::OUT_W;
    localparam int NL = m3vt_pkg::SIDE_LAT;

    logic [m3vt_pkg::ROW_W-1:0] r_row0, r_row1, r_row2;
    logic                       r_ren;
    logic                       adv;

    logic [1:0]                 r_vld;
    logic [1:0]                 r_ren_d;
    logic [2:0][OW-1:0]         mac_p;
    logic [2:0][OW-1:0]         r_p3, r_p4;
    logic                       r_vld3, r_vld4, r_ren3, r_ren4;
    logic [m3vt_pkg::SQ_W-1:0]  r_sq [3];
    logic [m3vt_pkg::SQ_W-1:0]  r_psq [3];
    logic [m3vt_pkg::NORM_W-1:0] r_n;
    m3vt_pkg::t_side            r_side [NL];
    m3vt_pkg::t_side            n_side;
    logic [m3vt_pkg::QUO_W-1:0] quo [3];
    logic [m3vt_pkg::ROOT_W-1:0] root [3];
    logic [2:0][OW-1:0]         n_out;
    logic [2:0][OW-1:0]         r_out;
    logic                       r_out_vld, r_out_degen;

    assign adv        = !r_out_vld || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= m3vt_pkg::ROW0_RST;
            r_row1 <= m3vt_pkg::ROW1_RST;
            r_row2 <= m3vt_pkg::ROW2_RST;
            r_ren  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (m3vt_pkg::t_reg_idx'(i_cfg_idx))
                m3vt_pkg::REG_ROW0:  r_row0 <= i_cfg_data;
                m3vt_pkg::REG_ROW1:  r_row1 <= i_cfg_data;
                m3vt_pkg::REG_ROW2:  r_row2 <= i_cfg_data;
                m3vt_pkg::REG_RENRM: r_ren  <= i_cfg_data[0];
                default:             r_ren  <= r_ren;
            endcase
        end
    end

    m3vt_mac #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_mac (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_row0 (r_row0),
        .i_row1 (r_row1),
        .i_row2 (r_row2),
        .i_x    (i_in_x),
        .i_y    (i_in_y),
        .i_z    (i_in_z),
        .o_p    (mac_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (adv) begin
            r_vld  <= {r_vld[0], i_in_valid};
            r_vld3 <= r_vld[1];
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [OW-1:0] mag;
        if (adv) begin
            r_ren_d <= {r_ren_d[0], r_ren};
            r_p3    <= mac_p;
            r_ren3  <= r_ren_d[1];
            for (int r = 0; r < 3; r++) begin
                mag     = mac_p[r][OW-1] ? (OW'(0) - mac_p[r]) : mac_p[r];
                r_sq[r] <= m3vt_pkg::SQ_W'(mag) * m3vt_pkg::SQ_W'(mag);
            end
            r_p4   <= r_p3;
            r_ren4 <= r_ren3;
            r_psq  <= r_sq;
            r_n    <= m3vt_pkg::NORM_W'(r_sq[0]) + m3vt_pkg::NORM_W'(r_sq[1])
                    + m3vt_pkg::NORM_W'(r_sq[2]);
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_lane
        m3vt_div u_div (
            .i_clk (i_clk),
            .i_adv (adv),
            .i_num (r_psq[r]),
            .i_den (r_n),
            .o_quo (quo[r])
        );
        m3vt_sqrt u_sqrt (
            .i_clk  (i_clk),
            .i_adv  (adv),
            .i_rad  (quo[r]),
            .o_root (root[r])
        );
    end

    always_comb begin
        n_side.vld   = r_vld4;
        n_side.ren   = r_ren4;
        n_side.degen = r_n == '0;
        n_side.p     = r_p4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NL; k++) begin
                r_side[k].vld <= 1'b0;
            end
        end else if (adv) begin
            r_side[0] <= n_side;
            for (int k = 1; k < NL; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_comb begin
        logic [m3vt_pkg::UNIT_W-1:0] q;
        for (int r = 0; r < 3; r++) begin
            q = m3vt_pkg::UNIT_W'((m3vt_pkg::ROOT_W + 1)'(root[r]) + 1'b1 >> 1);
            if (!r_side[NL-1].ren) begin
                n_out[r] = r_side[NL-1].p[r];
            end else if (r_side[NL-1].degen) begin
                n_out[r] = '0;
            end else if (r_side[NL-1].p[r][OW-1]) begin
                n_out[r] = OW'(0) - OW'(q);
            end else begin
                n_out[r] = OW'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_side[NL-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out       <= n_out;
            r_out_degen <= r_side[NL-1].ren && r_side[NL-1].degen;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_out_x          = r_out[0];
    assign o_out_y          = r_out[1];
    assign o_out_z          = r_out[2];
    assign o_out_degenerate = r_out_degen;

`ifndef ASSERT_OFF
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_degenerate |-> o_out_x == '0 && o_out_y == '0 && o_out_z == '0)
        else $error("degenerate result with nonzero components");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while output stalled");

    a_load_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_ready))
        else $error("output loaded without pipeline advance");
`endif

endmodule

/* design/m3vt_mac.sv */
// ----------------------------------------------------------------------------
// m3vt_mac
// Two-stage matrix-vector product: nine registered multiplies, then the row
// sums rounded half away from zero to Q8.15 and saturated.
// ----------------------------------------------------------------------------
module m3vt_mac #(
    parameter int COEF_WIDTH = 18
) (
    input  logic                                   i_clk,
    input  logic                                   i_adv,
    input  logic [m3vt_pkg::ROW_W-1:0]             i_row0,
    input  logic [m3vt_pkg::ROW_W-1:0]             i_row1,
    input  logic [m3vt_pkg::ROW_W-1:0]             i_row2,
    input  logic signed [m3vt_pkg::IN_W-1:0]       i_x,
    input  logic signed [m3vt_pkg::IN_W-1:0]       i_y,
    input  logic signed [m3vt_pkg::IN_W-1:0]       i_z,
    output logic [2:0][m3vt_pkg::OUT_W-1:0]        o_p
);

    localparam int EXT_W = (3 * COEF_WIDTH > m3vt_pkg::ROW_W) ?
                           3 * COEF_WIDTH : m3vt_pkg::ROW_W;
    localparam int PW = COEF_WIDTH + m3vt_pkg::IN_W;
    localparam int SW = PW + 2;
    localparam int RW = SW + 1;

    logic [EXT_W-1:0]               ext [3];
    logic signed [m3vt_pkg::IN_W-1:0] vec [3];
    logic signed [PW-1:0]           r_prod [3][3];
    logic signed [PW-1:0]           n_prod [3][3];
    logic [2:0][m3vt_pkg::OUT_W-1:0] n_p;
    logic [2:0][m3vt_pkg::OUT_W-1:0] r_p;

    always_comb begin
        ext[0] = EXT_W'(i_row0);
        ext[1] = EXT_W'(i_row1);
        ext[2] = EXT_W'(i_row2);
        vec[0] = i_x;
        vec[1] = i_y;
        vec[2] = i_z;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_prod[r][c] = $signed(ext[r][c*COEF_WIDTH +: COEF_WIDTH]) * vec[c];
            end
        end
    end

    always_comb begin
        logic signed [SW-1:0] s;
        logic [SW-1:0]        mag;
        logic [RW-1:0]        rnd;
        logic [m3vt_pkg::OUT_W-1:0] sat;
        for (int r = 0; r < 3; r++) begin
            s   = SW'(r_prod[r][0]) + SW'(r_prod[r][1]) + SW'(r_prod[r][2]);
            mag = s[SW-1] ? SW'(-s) : SW'(s);
            rnd = (RW'(mag) + (RW'(1) << (m3vt_pkg::FRAC_W - 1))) >> m3vt_pkg::FRAC_W;
            if (s[SW-1]) begin
                sat    = (rnd > RW'(m3vt_pkg::OUT_MIN_MAG)) ? m3vt_pkg::OUT_MIN_MAG
                                                            : rnd[m3vt_pkg::OUT_W-1:0];
                n_p[r] = m3vt_pkg::OUT_W'(0) - sat;
            end else begin
                sat    = (rnd > RW'(m3vt_pkg::OUT_MAX)) ? m3vt_pkg::OUT_MAX
                                                        : rnd[m3vt_pkg::OUT_W-1:0];
                n_p[r] = sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
            r_p    <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

/* design/m3vt_div.sv */
// ----------------------------------------------------------------------------
// m3vt_div
// Pipelined restoring divider, one quotient bit per stage:
// quotient = floor(num * 2^32 / den), with num <= den.
// ----------------------------------------------------------------------------
module m3vt_div (
    input  logic                              i_clk,
    input  logic                              i_adv,
    input  logic [m3vt_pkg::SQ_W-1:0]         i_num,
    input  logic [m3vt_pkg::NORM_W-1:0]       i_den,
    output logic [m3vt_pkg::QUO_W-1:0]        o_quo
);

    localparam int DW = m3vt_pkg::NORM_W;
    localparam int QW = m3vt_pkg::QUO_W;

    logic [DW:0]   r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW:0]   rem_in;
        logic [DW:0]   diff;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in = (DW + 1)'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = {r_rem[k-1][DW-1:0], 1'b0};
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign ge   = rem_in >= {1'b0, den_in};
        assign diff = rem_in - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_quo[k] <= {quo_in[QW-2:0], ge};
            end
        end

        if (k < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k] <= ge ? diff : rem_in;
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

/* design/m3vt_sqrt.sv */
// ----------------------------------------------------------------------------
// m3vt_sqrt
// Pipelined integer square root, one root bit per stage: floor(sqrt(rad)).
// ----------------------------------------------------------------------------
module m3vt_sqrt (
    input  logic                         i_clk,
    input  logic                         i_adv,
    input  logic [m3vt_pkg::QUO_W-1:0]   i_rad,
    output logic [m3vt_pkg::ROOT_W-1:0]  o_root
);

    localparam int FW = m3vt_pkg::QUO_W;
    localparam int RW = m3vt_pkg::ROOT_W;
    localparam int TW = FW + 2;

    logic [FW-1:0] r_rem [RW-1];
    logic [RW-1:0] r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [FW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [TW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));
        assign ge    = TW'(rem_in) >= trial;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_root[k] <= ge ? (root_in | (RW'(1) << B)) : root_in;
            end
        end

        if (k < RW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[k] <= ge ? (rem_in - trial[FW-1:0]) : rem_in;
                end
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule
